// File: rtl/core/adc_scan_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// ADC scan deframer assertion macros
// Shared property macros for the concurrent checks at the top level.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_DEFRAMER_TOP_DEFINES_SVH
`define ADC_SCAN_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/asd_pkg.sv
// ----------------------------------------------------------------------------
// ADC scan deframer package
// Widths, codes, reset values and shared types of the scan deframer.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MV_W        = 12;
    localparam int CHAN_W      = 4;
    localparam int SLOT_W      = 4;
    localparam int MAP_W       = 40;
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = SAMPLE_BITS + MV_W;
    localparam int OUT_FIELDS  = 8;

    localparam int SLOTS_DEF       = 8;
    localparam int HW_CHANNELS_DEF = 10;

    localparam logic [PROD_W-1:0] RAW_TOP  = PROD_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [PROD_W-1:0] RAW_HALF = PROD_W'(((1 << SAMPLE_BITS) - 1) / 2);

    localparam logic [SLOT_W-1:0] SLOT_UNMAPPED = '1;

    localparam logic [SLOT_W-1:0] ACTIVE_SLOTS_RST  = SLOT_W'(8);
    localparam logic [MAP_W-1:0]  SLOT_MAP_RST      = '1;
    localparam logic [MV_W-1:0]   FULL_SCALE_MV_RST = MV_W'(3100);

    typedef enum logic {
        OP_CONVERSION = 1'b0,
        OP_RESYNC     = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_SLOTS = 2'd0,
        CFG_SLOT_MAP     = 2'd1,
        CFG_FULL_SCALE   = 2'd2
    } t_cfg_idx;

    // Mapping configuration seen by the scan controller.
    typedef struct packed {
        logic [SLOT_W-1:0] active_slots;
        logic [MAP_W-1:0]  slot_map;
    } t_map_cfg;

    // A converted item entering the scan controller.
    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] chan;
        logic [MV_W-1:0]   mv;
    } t_conv;

    // Status returned by the scan controller.
    typedef struct packed {
        logic fire;
        logic emit;
    } t_ctl_stat;

endpackage

// File: rtl/core/asd_mv_scale.sv
// ----------------------------------------------------------------------------
// Millivolt scaling multiplier
// Forms raw * full_scale + half the top code, the dividend of the conversion.
// ----------------------------------------------------------------------------
module asd_mv_scale import asd_pkg::*; (
    input  logic [SAMPLE_BITS-1:0] i_raw,
    input  logic [MV_W-1:0]        i_full_scale,
    output logic [PROD_W-1:0]      o_prod
);

    logic [PROD_W-1:0] prod;

    assign prod   = PROD_W'(i_raw) * PROD_W'(i_full_scale);
    assign o_prod = prod + RAW_HALF;

endmodule

// File: rtl/core/asd_mv_div.sv
// ----------------------------------------------------------------------------
// Divide by the top raw code
// Exact quotient of the scaled product by 2^SAMPLE_BITS - 1.
// ----------------------------------------------------------------------------
module asd_mv_div import asd_pkg::*; (
    input  logic [PROD_W-1:0] i_prod,
    output logic [MV_W-1:0]   o_mv
);

    // Since the divisor is one below a power of two, the high part is a first
    // estimate and the remainder is the low part plus that estimate. The
    // remainder stays below twice the divisor plus one, so two compares finish.
    logic [MV_W-1:0]        q_hi;
    logic [SAMPLE_BITS:0]   rem;
    logic [SAMPLE_BITS:0]   top;
    logic [SAMPLE_BITS:0]   top2;

    assign q_hi = i_prod[PROD_W-1 -: MV_W];
    assign rem  = (SAMPLE_BITS+1)'(i_prod[SAMPLE_BITS-1:0]) + (SAMPLE_BITS+1)'(q_hi);
    assign top  = RAW_TOP[SAMPLE_BITS:0];
    assign top2 = {RAW_TOP[SAMPLE_BITS-1:0], 1'b0};

    assign o_mv = q_hi + MV_W'(rem >= top) + MV_W'(rem >= top2);

endmodule

// File: rtl/core/asd_scan_ctrl.sv
// ----------------------------------------------------------------------------
// Scan controller
// Slot lookup, sequence check, scan store and the registered scan output.
// ----------------------------------------------------------------------------
module asd_scan_ctrl import asd_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HW_CHANNELS = HW_CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_map_cfg        i_cfg,
    input  logic            i_valid,
    input  t_conv           i_item,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [MV_W-1:0] o_mv [OUT_FIELDS],
    output t_ctl_stat       o_stat
);

    localparam int SIW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAP_EXT_W = SLOT_W << CHAN_W;
    localparam logic [SLOT_W:0] SLOTS_C = (SLOT_W+1)'(SLOTS);
    localparam logic [CHAN_W:0] HWC_C   = (CHAN_W+1)'(HW_CHANNELS);

    logic [SLOT_W-1:0]    r_exp;
    logic [MV_W-1:0]      r_store [SLOTS];
    logic                 r_out_valid;
    logic [MV_W-1:0]      r_mv [OUT_FIELDS];

    logic [SLOT_W-1:0]    n_exp;
    logic [MV_W-1:0]      n_store [SLOTS];
    logic [MV_W-1:0]      n_mv [OUT_FIELDS];

    logic [SLOT_W-1:0]    act;
    logic [MAP_EXT_W-1:0] map_ext;
    logic [SLOT_W-1:0]    entry;
    logic [SLOT_W-1:0]    entry_inc;
    logic                 keep;
    logic                 emit;
    logic                 fire;

    assign act = ({1'b0, i_cfg.active_slots} > SLOTS_C) ? SLOTS_C[SLOT_W-1:0]
                                                        : i_cfg.active_slots;

    // Channels past the table read zero bits and so land on slot zero.
    assign map_ext = {(MAP_EXT_W - MAP_W)'(0), i_cfg.slot_map};
    assign entry   = map_ext[i_item.chan * SLOT_W +: SLOT_W];

    // An out-of-order slot is kept only when it is slot zero, which restarts
    // the scan; in both kept cases the next expected slot follows the entry, or is zero after a full scan.
    assign keep = (i_item.op == OP_CONVERSION) && ({1'b0, i_item.chan} < HWC_C)
               && (entry != SLOT_UNMAPPED) && (entry < act)
               && ((entry == r_exp) || (entry == '0));
    assign entry_inc = entry + SLOT_W'(1);
    assign emit      = keep && (entry_inc == act);
    assign fire      = i_valid && (!emit || !r_out_valid || !i_out_stall);
    assign n_exp     = (keep && !emit) ? entry_inc : '0;

    always_comb begin
        n_store = r_store;
        if (keep) begin
            n_store[entry[SIW-1:0]] = i_item.mv;
        end
    end

    for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_out
        if (k < SLOTS) begin : g_live
            assign n_mv[k] = n_store[k];
        end else begin : g_none
            assign n_mv[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_store[s] <= '0;
            end
        end else begin
            if (fire) begin
                r_exp   <= n_exp;
                r_store <= n_store;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_mv <= n_mv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mv        = r_mv;
    assign o_stat.fire = fire;
    assign o_stat.emit = emit;

endmodule

// File: rtl/core/adc_scan_deframer_top.sv
// ----------------------------------------------------------------------------
// ADC scan deframer
// Rebuilds complete scans of rounded millivolts from a tagged ADC stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall | i_op, i_adc_channel, i_raw_code
//  out     | output    | o_out_valid / i_out_stall | o_mv_slot0 .. o_mv_slot7
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One conversion is accepted per clock while the input is not stalled. An item
// passes an input register, a register after the scaling multiplier and the
// scan controller, whose output register presents a scan once its last
// conversion has passed both. Reset is synchronous; no clearing pass is needed.
// While a result waits at the output, items that complete no scan keep flowing,
// and input stalls only once both pipeline registers are full behind it.
module adc_scan_deframer_top import asd_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HW_CHANNELS = HW_CHANNELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_op,
    input  logic [CHAN_W-1:0]      i_adc_channel,
    input  logic [SAMPLE_BITS-1:0] i_raw_code,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [MV_W-1:0]        o_mv_slot0,
    output logic [MV_W-1:0]        o_mv_slot1,
    output logic [MV_W-1:0]        o_mv_slot2,
    output logic [MV_W-1:0]        o_mv_slot3,
    output logic [MV_W-1:0]        o_mv_slot4,
    output logic [MV_W-1:0]        o_mv_slot5,
    output logic [MV_W-1:0]        o_mv_slot6,
    output logic [MV_W-1:0]        o_mv_slot7,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

`include "adc_scan_deframer_top_defines.svh"

    logic [SLOT_W-1:0]      r_active_slots;
    logic [MAP_W-1:0]       r_slot_map;
    logic [MV_W-1:0]        r_full_scale;

    logic                   r1_valid;
    logic                   r1_op;
    logic [CHAN_W-1:0]      r1_chan;
    logic [SAMPLE_BITS-1:0] r1_raw;

    logic                   r2_valid;
    logic                   r2_op;
    logic [CHAN_W-1:0]      r2_chan;
    logic [PROD_W-1:0]      r2_prod;

    logic [PROD_W-1:0]      prod;
    logic [MV_W-1:0]        mv;
    t_conv                  item;
    t_map_cfg               map_cfg;
    t_ctl_stat              stat;
    logic [MV_W-1:0]        mv_out [OUT_FIELDS];
    logic                   adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACTIVE_SLOTS_RST;
            r_slot_map     <= SLOT_MAP_RST;
            r_full_scale   <= FULL_SCALE_MV_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_SLOTS: r_active_slots <= i_cfg_data[SLOT_W-1:0];
                CFG_SLOT_MAP:     r_slot_map     <= i_cfg_data[MAP_W-1:0];
                CFG_FULL_SCALE:   r_full_scale   <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // The second register moves when it is empty or its item is taken.
    assign adv2       = !r2_valid || stat.fire;
    assign o_in_stall = r1_valid && !adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r1_valid <= i_in_valid;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r1_op   <= i_op;
            r1_chan <= i_adc_channel;
            r1_raw  <= i_raw_code;
        end
        if (adv2) begin
            r2_op   <= r1_op;
            r2_chan <= r1_chan;
            r2_prod <= prod;
        end
    end

    asd_mv_scale u_scale (
        .i_raw        (r1_raw),
        .i_full_scale (r_full_scale),
        .o_prod       (prod)
    );

    asd_mv_div u_div (
        .i_prod (r2_prod),
        .o_mv   (mv)
    );

    assign item.op              = r2_op;
    assign item.chan            = r2_chan;
    assign item.mv              = mv;
    assign map_cfg.active_slots = r_active_slots;
    assign map_cfg.slot_map     = r_slot_map;

    asd_scan_ctrl #(
        .SLOTS       (SLOTS),
        .HW_CHANNELS (HW_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (map_cfg),
        .i_valid     (r2_valid),
        .i_item      (item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_mv        (mv_out),
        .o_stat      (stat)
    );

    assign o_mv_slot0 = mv_out[0];
    assign o_mv_slot1 = mv_out[1];
    assign o_mv_slot2 = mv_out[2];
    assign o_mv_slot3 = mv_out[3];
    assign o_mv_slot4 = mv_out[4];
    assign o_mv_slot5 = mv_out[5];
    assign o_mv_slot6 = mv_out[6];
    assign o_mv_slot7 = mv_out[7];

    // A held item in the controller is only ever blocked by a stalled result.
    `ASD_ASSERT_NOW(a_ctrl_block, r2_valid && !stat.fire, o_out_valid && i_out_stall, "controller blocked without a stalled result")
    // A completed scan is presented on the following cycle.
    `ASD_ASSERT_NEXT(a_emit_shown, stat.fire && stat.emit, o_out_valid, "completed scan not presented")
    // Input stalls only when both pipeline registers are occupied.
    `ASD_ASSERT_NOW(a_stall_full, o_in_stall, r1_valid && r2_valid, "input stalled with room in the pipeline")

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// ADC scan deframer testbench
// A table of directed conversions and register writes, then random
// configuration phases with mostly well-formed scans, random input gaps and
// output stalls (one phase runs steady). Every scan transfer is compared slot
// by slot against an independent scan builder, or the typed row's own scan.
// ----------------------------------------------------------------------------
module testbench;
    import asd_pkg::*;

    localparam int SETTLE   = 8;
    localparam int RUN_CAP  = 10_000_000;

    typedef logic [OUT_FIELDS-1:0][MV_W-1:0] t_scan;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_op                    op;
        logic [CHAN_W-1:0]      chan;
        logic [SAMPLE_BITS-1:0] raw;
        bit                     typed;
        bit                     emit;
        t_scan                  scan;
        t_cfg_idx               idx;
        logic [CFG_DATA_W-1:0]  data;
    } t_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   i_op          = 1'b0;
    logic [CHAN_W-1:0]      i_adc_channel = '0;
    logic [SAMPLE_BITS-1:0] i_raw_code    = '0;
    logic                   i_out_stall   = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [MV_W-1:0]        o_mv_slot0, o_mv_slot1, o_mv_slot2, o_mv_slot3;
    logic [MV_W-1:0]        o_mv_slot4, o_mv_slot5, o_mv_slot6, o_mv_slot7;

    // Typed expectation that travels with the payload currently offered.
    bit    cur_typed = 1'b0;
    bit    cur_emit  = 1'b0;
    t_scan cur_scan  = '0;

    // Scan builder state, a private copy of the block's registers and store.
    logic [SLOT_W-1:0] pr_active_slots = ACTIVE_SLOTS_RST;
    logic [MAP_W-1:0]  pr_slot_map     = SLOT_MAP_RST;
    logic [MV_W-1:0]   pr_full_scale   = FULL_SCALE_MV_RST;
    logic [SLOT_W-1:0] pr_next_slot    = '0;
    logic [MV_W-1:0]   pr_store [SLOTS_DEF] = '{default: '0};

    t_scan scans_due [$];
    t_row  steps [$];
    int    errors        = 0;
    bit    sender_steady = 1'b0;
    bit    out_steady    = 1'b0;
    int    stall_hold    = 0;

    adc_scan_deframer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_adc_channel (i_adc_channel),
        .i_raw_code    (i_raw_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mv_slot0    (o_mv_slot0),
        .o_mv_slot1    (o_mv_slot1),
        .o_mv_slot2    (o_mv_slot2),
        .o_mv_slot3    (o_mv_slot3),
        .o_mv_slot4    (o_mv_slot4),
        .o_mv_slot5    (o_mv_slot5),
        .o_mv_slot6    (o_mv_slot6),
        .o_mv_slot7    (o_mv_slot7),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [MV_W-1:0] scale_mv(logic [SAMPLE_BITS-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(pr_full_scale) + RAW_HALF;
        return MV_W'(prod / RAW_TOP);
    endfunction

    // Places one conversion and returns 1 when it completes a scan.
    function automatic bit rebuild_scan(t_op op, logic [CHAN_W-1:0] chan,
                                        logic [SAMPLE_BITS-1:0] raw, output t_scan scan);
        int                act;
        logic [SLOT_W-1:0] slot;
        scan = '0;
        act  = (pr_active_slots > SLOTS_DEF) ? SLOTS_DEF : int'(pr_active_slots);
        if (op == OP_RESYNC || chan >= HW_CHANNELS_DEF) begin
            pr_next_slot = '0;
            return 1'b0;
        end
        slot = SLOT_W'(pr_slot_map >> (SLOT_W * int'(chan)));
        if (slot == SLOT_UNMAPPED || int'(slot) >= act) begin
            pr_next_slot = '0;
            return 1'b0;
        end
        // Out of order: realign, keeping the conversion only if it opens a scan.
        if (slot != pr_next_slot) begin
            pr_next_slot = '0;
            if (slot != '0)
                return 1'b0;
        end
        pr_store[slot] = scale_mv(raw);
        pr_next_slot   = pr_next_slot + 1'b1;
        if (int'(pr_next_slot) != act)
            return 1'b0;
        pr_next_slot = '0;
        for (int k = 0; k < OUT_FIELDS; k++)
            scan[k] = pr_store[k];
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_raw();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SAMPLE_BITS'($urandom());
    endfunction

    task automatic add_item(t_op op, int chan, int raw, bit typed = 1'b0,
                            bit emit = 1'b0, t_scan scan = '0);
        t_row row;
        row       = '{kind: ROW_ITEM, op: OP_CONVERSION, idx: CFG_ACTIVE_SLOTS, default: '0};
        row.kind  = ROW_ITEM;
        row.op    = op;
        row.chan  = CHAN_W'(chan);
        row.raw   = SAMPLE_BITS'(raw);
        row.typed = typed;
        row.emit  = emit;
        row.scan  = scan;
        steps.push_back(row);
    endtask

    task automatic add_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row      = '{kind: ROW_CFG, op: OP_CONVERSION, idx: CFG_ACTIVE_SLOTS, default: '0};
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        steps.push_back(row);
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (scans_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        pause_until_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offers one item and returns at the edge of its transfer, valid still high.
    task automatic send_item(t_op op, logic [CHAN_W-1:0] chan, logic [SAMPLE_BITS-1:0] raw,
                             bit typed = 1'b0, bit emit = 1'b0, t_scan scan = '0);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_adc_channel <= chan;
        i_raw_code    <= raw;
        cur_typed     <= typed;
        cur_emit      <= emit;
        cur_scan      <= scan;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic send_noise();
        t_op op;
        op = ($urandom_range(0, 4) == 0) ? OP_RESYNC : OP_CONVERSION;
        send_item(op, CHAN_W'($urandom_range(0, 15)), pick_raw());
    endtask

    always @(posedge i_clk) begin : out_stall_gen
        int r;
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (out_steady) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(0, 4);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin : scan_checker
        t_scan want;
        t_scan got;
        bit    made;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACTIVE_SLOTS: pr_active_slots = i_cfg_data[SLOT_W-1:0];
                    CFG_SLOT_MAP:     pr_slot_map     = i_cfg_data[MAP_W-1:0];
                    CFG_FULL_SCALE:   pr_full_scale   = i_cfg_data[MV_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                made = rebuild_scan(t_op'(i_op), i_adc_channel, i_raw_code, want);
                if (cur_typed) begin
                    made = cur_emit;
                    want = cur_scan;
                end
                if (made)
                    scans_due.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_mv_slot7, o_mv_slot6, o_mv_slot5, o_mv_slot4,
                       o_mv_slot3, o_mv_slot2, o_mv_slot1, o_mv_slot0};
                if (scans_due.size() == 0) begin
                    $error("scan transfer with no scan expected");
                    errors++;
                end else begin
                    want = scans_due.pop_front();
                    for (int k = 0; k < OUT_FIELDS; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("mv_slot%0d: expected %0d, actual %0d", k, want[k], got[k]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int                     act_val;
        int                     eff;
        int                     fs_val;
        int                     n_items;
        int                     sent;
        int                     j;
        int                     c;
        int                     tmp;
        int                     chans [HW_CHANNELS_DEF];
        bit                     zero_map;
        bit                     paused;
        logic [CHAN_W-1:0]      chan_of_slot [SLOTS_DEF];
        logic [MAP_W-1:0]       map;
        logic [SLOT_W-1:0]      nib;
        logic [63:0]            hi;
        logic [CFG_DATA_W-1:0]  cfg;

        // After reset nothing is mapped, so every conversion is dropped.
        add_item(OP_CONVERSION, 0, 4095, 1'b1);
        add_item(OP_CONVERSION, 9, 0, 1'b1);
        add_item(OP_CONVERSION, 15, 4095, 1'b1);
        add_item(OP_RESYNC, 0, 0, 1'b1);
        // Four slots; channel 4 and 8 unmapped, channel 5 and 6 at or beyond
        // the active count, channel 7 doubles slot 3 and channel 9 slot 1.
        add_cfg(CFG_ACTIVE_SLOTS, CFG_DATA_W'(4));
        add_cfg(CFG_SLOT_MAP, 40'h1F345F3210);
        add_cfg(CFG_FULL_SCALE, CFG_DATA_W'(4095));
        add_item(OP_CONVERSION, 0, 0);
        add_item(OP_CONVERSION, 1, 4095);
        add_item(OP_CONVERSION, 2, 1);
        add_item(OP_CONVERSION, 3, 2048, 1'b1, 1'b1,
                 {12'd0, 12'd0, 12'd0, 12'd0, 12'd2048, 12'd1, 12'd4095, 12'd0});
        add_item(OP_CONVERSION, 0, 100);
        add_item(OP_CONVERSION, 2, 5);
        add_item(OP_CONVERSION, 1, 7);
        add_item(OP_CONVERSION, 0, 9);
        add_item(OP_CONVERSION, 4, 11);
        add_item(OP_CONVERSION, 0, 12);
        add_item(OP_CONVERSION, 6, 14);
        add_item(OP_CONVERSION, 0, 15);
        add_item(OP_CONVERSION, 12, 16);
        add_item(OP_CONVERSION, 0, 20);
        add_item(OP_CONVERSION, 1, 21);
        add_item(OP_CONVERSION, 0, 22);
        add_item(OP_CONVERSION, 9, 23);
        add_item(OP_CONVERSION, 2, 24);
        add_item(OP_CONVERSION, 7, 25);
        add_item(OP_CONVERSION, 0, 30);
        add_item(OP_RESYNC, 5, 4095);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[i]) begin
            if (steps[i].kind == ROW_CFG)
                write_reg(steps[i].idx, steps[i].data);
            else
                send_item(steps[i].op, steps[i].chan, steps[i].raw,
                          steps[i].typed, steps[i].emit, steps[i].scan);
        end

        for (int p = 0; p < 8; p++) begin
            zero_map      = 1'b0;
            n_items       = 88;
            sender_steady = 1'b0;
            out_steady    = 1'b0;
            fs_val        = $urandom_range(1, 4095);
            case (p)
                0: begin
                    act_val = 4;
                    fs_val  = 4095;
                end
                1: begin
                    act_val = 8;
                    fs_val  = 3100;
                end
                2: begin
                    act_val  = 1;
                    fs_val   = 1;
                    zero_map = 1'b1;
                end
                3: begin
                    act_val = 0;
                    n_items = 25;
                end
                4: act_val = 15;
                5: begin
                    act_val       = 8;
                    fs_val        = 4095;
                    sender_steady = 1'b1;
                    out_steady    = 1'b1;
                end
                6: act_val = 4;
                default: act_val = $urandom_range(1, 8);
            endcase
            eff = (act_val > SLOTS_DEF) ? SLOTS_DEF : act_val;

            if (zero_map) begin
                map = '0;
                for (int s = 0; s < SLOTS_DEF; s++)
                    chan_of_slot[s] = CHAN_W'($urandom_range(0, HW_CHANNELS_DEF - 1));
            end else begin
                for (int i = 0; i < HW_CHANNELS_DEF; i++)
                    chans[i] = i;
                for (int i = HW_CHANNELS_DEF - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = chans[i];
                    chans[i] = chans[j];
                    chans[j] = tmp;
                end
                map = '1;
                for (int i = 0; i < HW_CHANNELS_DEF; i++) begin
                    c = chans[i];
                    if (i < eff) begin
                        nib             = SLOT_W'(i);
                        chan_of_slot[i] = CHAN_W'(c);
                    end else begin
                        case ($urandom_range(0, 2))
                            0: nib = SLOT_UNMAPPED;
                            1: nib = SLOT_W'($urandom_range(eff, 15));
                            default: nib = (eff != 0) ? SLOT_W'($urandom_range(0, eff - 1))
                                                      : SLOT_W'($urandom_range(0, 15));
                        endcase
                    end
                    map[SLOT_W*c +: SLOT_W] = nib;
                end
            end

            // Bits above a register's width are junk in half of the writes.
            hi  = {$urandom(), $urandom()};
            cfg = CFG_DATA_W'(act_val);
            if ($urandom_range(0, 1) != 0)
                cfg[CFG_DATA_W-1:SLOT_W] = hi[CFG_DATA_W-SLOT_W-1:0];
            write_reg(CFG_ACTIVE_SLOTS, cfg);
            write_reg(CFG_SLOT_MAP, map);
            hi  = {$urandom(), $urandom()};
            cfg = CFG_DATA_W'(fs_val);
            if ($urandom_range(0, 1) != 0)
                cfg[CFG_DATA_W-1:MV_W] = hi[CFG_DATA_W-MV_W-1:0];
            write_reg(CFG_FULL_SCALE, cfg);

            sent   = 0;
            paused = 1'b0;
            while (sent < n_items) begin
                if (p == 1 && !paused && sent >= n_items / 2) begin
                    pause_until_drained();
                    paused = 1'b1;
                end
                if (eff != 0 && $urandom_range(0, 99) < 75) begin
                    for (int s = 0; s < eff; s++) begin
                        if ($urandom_range(0, 99) < 5)
                            send_noise();
                        else
                            send_item(OP_CONVERSION, chan_of_slot[s], pick_raw());
                        sent++;
                    end
                end else begin
                    send_noise();
                    sent++;
                end
            end
        end

        sender_steady = 1'b0;
        out_steady    = 1'b0;
        pause_until_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : run_limit
        #(RUN_CAP);
        $display("FAILURE");
        $finish;
    end

endmodule
